>>> rtl/hrhp_pkg.sv
// Package for the HTTP request header parser: types, codes and character tables.
`default_nettype none

package hrhp_pkg;

  localparam int POS_BITS_DEF = 16;
  localparam int OUT_DEPTH    = 4;
  localparam int OUT_PTR_BITS = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_BITS = $clog2(OUT_DEPTH + 1);

  typedef enum logic [3:0] {
    PH_METHOD   = 4'd0,
    PH_PATH     = 4'd1,
    PH_VERSION  = 4'd2,
    PH_TO_LF    = 4'd3,
    PH_NAME     = 4'd4,
    PH_VALUE    = 4'd5,
    PH_AFTER_LF = 4'd6,
    PH_SKIP_ONE = 4'd7,
    PH_BODY     = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    KIND_METHOD  = 3'd0,
    KIND_PATH    = 3'd1,
    KIND_VERSION = 3'd2,
    KIND_NAME    = 3'd3,
    KIND_VALUE   = 3'd4,
    KIND_DONE    = 3'd5,
    KIND_ERROR   = 3'd6
  } kind_t;

  localparam logic [7:0] ERR_VERSION   = 8'd0;
  localparam logic [7:0] ERR_NAME_CRLF = 8'd1;
  localparam logic [7:0] ERR_NAME_CHAR = 8'd2;
  localparam logic [7:0] ERR_TRUNCATED = 8'd3;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int PROTO_PREFIX_LEN = 7;
  // "HTTP/1."
  localparam logic [7:0] VERSION_TEXT [PROTO_PREFIX_LEN] =
    '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h31, 8'h2E};

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] seg_start;
    logic [15:0] seg_length;
    logic [7:0]  header_index;
    logic [7:0]  info;
    logic        run_last;
  } res_t;

  // Token characters allowed in a header name.
  function automatic logic is_tchar(logic [7:0] b);
    logic ok;
    case (b) inside
      [8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
      8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
      8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

`default_nettype wire

>>> rtl/hrhp_in_if.sv
// Request byte channel: one byte of the request per beat.
`default_nettype none

interface hrhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/hrhp_out_if.sv
// Parse result channel: one segment, done or error report per beat.
`default_nettype none

interface hrhp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] seg_start;
  logic [15:0] seg_length;
  logic [7:0]  header_index;
  logic [7:0]  info;
  logic        run_last;

  modport source (output valid, kind, seg_start, seg_length, header_index, info, run_last,
                  input ready);
  modport sink   (input valid, kind, seg_start, seg_length, header_index, info, run_last,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/http_request_header_parser_top.sv
// Top level of the HTTP request header parser: byte decode, phase state and result queue.
//
//   channel | dir | payload                                                   | beat
//   req     | in  | data_byte, last_byte                                      | one byte
//   res     | out | kind, seg_start, seg_length, header_index, info, run_last | one result
//
// One byte is taken per cycle; decode and phase update finish in that cycle.
// A byte yields up to two results, which go into a 4-entry result queue.
// req.ready is high while the queue has room for two results, so with res
// stalled req stops taking bytes once three or more results are waiting.
// Synchronous reset returns the parser to the method phase with an empty queue.
`default_nettype none

module http_request_header_parser_top #(
  parameter int POS_BITS = hrhp_pkg::POS_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  hrhp_in_if.sink    req,
  hrhp_out_if.source res
);

  typedef logic [POS_BITS-1:0] pos_t;

  localparam pos_t POS_ONE = POS_BITS'(1);
  localparam pos_t POS_TWO = POS_BITS'(2);
  localparam pos_t POS_MAX = {POS_BITS{1'b1}};

  function automatic logic [15:0] rep16(pos_t v);
    logic [31:0] w;
    w = 32'(v);
    return w[15:0];
  endfunction

  // parser state
  hrhp_pkg::phase_t phase, phase_next;
  pos_t             byte_position;
  pos_t             segment_begin, segment_begin_next;
  logic [2:0]       vstep, vstep_next;
  logic [7:0]       headers_started, headers_started_next;
  logic             failed, failed_next;

  // result queue
  hrhp_pkg::res_t                   queue [hrhp_pkg::OUT_DEPTH];
  logic [hrhp_pkg::OUT_PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [hrhp_pkg::OUT_CNT_BITS-1:0] count;

  logic accept, pop;
  logic [7:0] b;
  pos_t p;

  assign b      = req.data_byte;
  assign p      = byte_position;
  assign accept = req.valid && req.ready;
  assign pop    = res.valid && res.ready;

  // byte classes
  logic is_sp, is_cr, is_lf, is_colon, is_digit, tchar, ver_ok, ver_done;
  logic [7:0] hdr_inc, hdr_idx;
  pos_t name_begin;

  assign is_sp    = (b == hrhp_pkg::CH_SPACE);
  assign is_cr    = (b == hrhp_pkg::CH_CR);
  assign is_lf    = (b == hrhp_pkg::CH_LF);
  assign is_colon = (b == hrhp_pkg::CH_COLON);
  assign is_digit = (b >= hrhp_pkg::CH_ZERO) && (b <= hrhp_pkg::CH_NINE);
  assign tchar    = hrhp_pkg::is_tchar(b);
  assign ver_done = (vstep == 3'(hrhp_pkg::PROTO_PREFIX_LEN));
  assign ver_ok   = !ver_done && (b == hrhp_pkg::VERSION_TEXT[vstep]);
  assign hdr_inc  = (headers_started == 8'hFF) ? headers_started : headers_started + 8'd1;
  assign hdr_idx  = (headers_started_next != 8'd0) ? headers_started_next - 8'd1 : 8'd0;
  // a name that starts right after a value's LF begins at this byte
  assign name_begin = (phase == hrhp_pkg::PH_AFTER_LF) ? p : segment_begin;

  // next state
  always_comb begin
    phase_next           = phase;
    segment_begin_next   = segment_begin;
    vstep_next           = vstep;
    headers_started_next = headers_started;
    failed_next          = failed;
    if (!failed) begin
      case (phase)
        hrhp_pkg::PH_METHOD: begin
          if (is_sp) begin
            segment_begin_next = p + POS_ONE;
            phase_next         = hrhp_pkg::PH_PATH;
          end
        end
        hrhp_pkg::PH_PATH: begin
          if (is_sp) begin
            phase_next = hrhp_pkg::PH_VERSION;
            vstep_next = 3'd0;
          end
        end
        hrhp_pkg::PH_VERSION: begin
          if (!ver_done) begin
            if (ver_ok) vstep_next = vstep + 3'd1;
            else        failed_next = 1'b1;
          end else if (is_digit) begin
            phase_next = hrhp_pkg::PH_TO_LF;
          end else begin
            failed_next = 1'b1;
          end
        end
        hrhp_pkg::PH_TO_LF: begin
          if (is_lf) begin
            segment_begin_next   = p + POS_ONE;
            headers_started_next = hdr_inc;
            phase_next           = hrhp_pkg::PH_NAME;
          end
        end
        hrhp_pkg::PH_NAME, hrhp_pkg::PH_AFTER_LF: begin
          if (phase == hrhp_pkg::PH_AFTER_LF && is_cr) begin
            phase_next = hrhp_pkg::PH_SKIP_ONE;
          end else if (phase == hrhp_pkg::PH_AFTER_LF && is_lf) begin
            segment_begin_next = p + POS_ONE;
            phase_next         = hrhp_pkg::PH_BODY;
          end else begin
            if (phase == hrhp_pkg::PH_AFTER_LF) begin
              segment_begin_next   = p;
              headers_started_next = hdr_inc;
              phase_next           = hrhp_pkg::PH_NAME;
            end
            if (is_colon) begin
              segment_begin_next = p + POS_TWO;
              phase_next         = hrhp_pkg::PH_VALUE;
            end else if (is_cr || is_lf || !tchar) begin
              failed_next = 1'b1;
            end
          end
        end
        hrhp_pkg::PH_VALUE: begin
          if (is_lf) phase_next = hrhp_pkg::PH_AFTER_LF;
        end
        hrhp_pkg::PH_SKIP_ONE: begin
          segment_begin_next = p + POS_ONE;
          phase_next         = hrhp_pkg::PH_BODY;
        end
        default: ;
      endcase
    end
  end

  // results of this byte
  hrhp_pkg::res_t first, second, r0, r1;
  logic has_first, has_second;
  pos_t value_d, value_len, body_bytes;

  assign value_d    = p - segment_begin;
  assign value_len  = (value_d != '0 && value_d != POS_MAX) ? value_d - POS_ONE : '0;
  assign body_bytes = p + POS_ONE - segment_begin_next;

  always_comb begin
    first     = '0;
    has_first = 1'b0;
    if (!failed) begin
      case (phase)
        hrhp_pkg::PH_METHOD, hrhp_pkg::PH_PATH: begin
          if (is_sp) begin
            has_first        = 1'b1;
            first.kind       = (phase == hrhp_pkg::PH_METHOD) ? hrhp_pkg::KIND_METHOD
                                                              : hrhp_pkg::KIND_PATH;
            first.seg_start  = rep16(segment_begin);
            first.seg_length = rep16(p - segment_begin);
          end
        end
        hrhp_pkg::PH_VERSION: begin
          has_first = 1'b1;
          if (ver_done && is_digit) begin
            first.kind       = hrhp_pkg::KIND_VERSION;
            first.seg_start  = rep16(p - POS_TWO);
            first.seg_length = 16'd3;
            first.info       = b - hrhp_pkg::CH_ZERO;
          end else if (!ver_ok) begin
            first.kind      = hrhp_pkg::KIND_ERROR;
            first.seg_start = rep16(p);
            first.info      = hrhp_pkg::ERR_VERSION;
          end else begin
            has_first = 1'b0;
          end
        end
        hrhp_pkg::PH_NAME, hrhp_pkg::PH_AFTER_LF: begin
          if (!(phase == hrhp_pkg::PH_AFTER_LF && (is_cr || is_lf))) begin
            has_first = 1'b1;
            if (is_colon) begin
              first.kind         = hrhp_pkg::KIND_NAME;
              first.seg_start    = rep16(name_begin);
              first.seg_length   = rep16(p - name_begin);
              first.header_index = hdr_idx;
            end else if (is_cr || is_lf) begin
              first.kind      = hrhp_pkg::KIND_ERROR;
              first.seg_start = rep16(p);
              first.info      = hrhp_pkg::ERR_NAME_CRLF;
            end else if (!tchar) begin
              first.kind      = hrhp_pkg::KIND_ERROR;
              first.seg_start = rep16(p);
              first.info      = hrhp_pkg::ERR_NAME_CHAR;
            end else begin
              has_first = 1'b0;
            end
          end
        end
        hrhp_pkg::PH_VALUE: begin
          if (is_lf) begin
            has_first          = 1'b1;
            first.kind         = hrhp_pkg::KIND_VALUE;
            first.seg_start    = rep16(segment_begin);
            first.seg_length   = rep16(value_len);
            first.header_index = hdr_idx;
          end
        end
        default: ;
      endcase
    end
    first.run_last = 1'b1;

    // end of request: report body or truncation
    second     = '0;
    has_second = req.last_byte && !failed_next;
    if (phase_next == hrhp_pkg::PH_BODY) begin
      second.kind       = hrhp_pkg::KIND_DONE;
      second.seg_start  = rep16(segment_begin_next);
      second.seg_length = rep16(body_bytes);
      second.info       = headers_started_next;
    end else begin
      second.kind      = hrhp_pkg::KIND_ERROR;
      second.seg_start = rep16(p);
      second.info      = hrhp_pkg::ERR_TRUNCATED;
    end
    second.run_last = 1'b1;

    if (has_first) begin
      r0          = first;
      r0.run_last = !has_second;
      r1          = second;
    end else begin
      r0 = second;
      r1 = second;
    end
  end

  logic [1:0] n_push;
  assign n_push = accept ? (2'(has_first) + 2'(has_second)) : 2'd0;

  // parser registers
  always_ff @(posedge clk) begin
    if (rst || (accept && req.last_byte)) begin
      phase           <= hrhp_pkg::PH_METHOD;
      byte_position   <= '0;
      segment_begin   <= '0;
      vstep           <= 3'd0;
      headers_started <= 8'd0;
      failed          <= 1'b0;
    end else if (accept) begin
      phase           <= phase_next;
      byte_position   <= p + POS_ONE;
      segment_begin   <= segment_begin_next;
      vstep           <= vstep_next;
      headers_started <= headers_started_next;
      failed          <= failed_next;
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) queue[wr_ptr] <= r0;
    if (n_push == 2'd2) queue[wr_ptr + hrhp_pkg::OUT_PTR_BITS'(1)] <= r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + hrhp_pkg::OUT_PTR_BITS'(n_push);
      if (pop) rd_ptr <= rd_ptr + hrhp_pkg::OUT_PTR_BITS'(1);
      count <= count + hrhp_pkg::OUT_CNT_BITS'(n_push) - hrhp_pkg::OUT_CNT_BITS'(pop);
    end
  end

  assign req.ready        = (count <= hrhp_pkg::OUT_CNT_BITS'(hrhp_pkg::OUT_DEPTH - 2));
  assign res.valid        = (count != '0);
  assign res.kind         = queue[rd_ptr].kind;
  assign res.seg_start    = queue[rd_ptr].seg_start;
  assign res.seg_length   = queue[rd_ptr].seg_length;
  assign res.header_index = queue[rd_ptr].header_index;
  assign res.info         = queue[rd_ptr].info;
  assign res.run_last     = queue[rd_ptr].run_last;

  // checks
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= hrhp_pkg::OUT_CNT_BITS'(hrhp_pkg::OUT_DEPTH))
    else $error("result queue overflow");

  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    accept && req.last_byte |=> phase == hrhp_pkg::PH_METHOD && !failed
                                && byte_position == '0)
    else $error("parser not back in method phase after last byte");

  a_failed_holds: assert property (@(posedge clk) disable iff (rst)
    failed && !(accept && req.last_byte) |=> failed)
    else $error("error state dropped before last byte");

  a_one_error: assert property (@(posedge clk) disable iff (rst)
    accept && failed |-> n_push == 2'd0)
    else $error("result produced after an error");

endmodule

`default_nettype wire
